// File: hw/rtl/pra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pra_pkg
// Shared constants, codes and channel payload types of the packet reassembler.
// ----------------------------------------------------------------------------
package pra_pkg;

   // default sizing
   localparam int NUM_CHANNELS_DEF       = 8;
   localparam int NUM_SLOTS_DEF          = 16;
   localparam int SLOT_PAYLOAD_BYTES_DEF = 2048;

   // header layout: magic, then little-endian total length
   localparam int       HEADER_BYTES = 6;
   localparam int       LEN_BYTES    = 4;
   localparam logic [7:0] MAGIC0     = 8'h24;
   localparam logic [7:0] MAGIC1     = 8'h40;

   // request modes
   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;
   localparam logic [1:0] MODE_RSVD = 2'd3;

   // response status codes
   localparam logic [3:0] STAT_STORED   = 4'd0;
   localparam logic [3:0] STAT_COMPLETE = 4'd1;
   localparam logic [3:0] STAT_HDR_PEND = 4'd2;
   localparam logic [3:0] STAT_BAD_HDR  = 4'd3;
   localparam logic [3:0] STAT_NO_SLOT  = 4'd4;
   localparam logic [3:0] STAT_BAD_LEN  = 4'd5;
   localparam logic [3:0] STAT_POPPED   = 4'd6;
   localparam logic [3:0] STAT_EMPTY    = 4'd7;
   localparam logic [3:0] STAT_READ     = 4'd8;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  channel;
      logic [7:0]  data_byte;
      logic        from_network;
      logic [15:0] bytes_left;
      logic [3:0]  read_slot;
      logic [11:0] read_offset;
   } pra_req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  done_slot;
      logic [11:0] done_length;
      logic        front_ready;
      logic [2:0]  front_channel;
      logic [3:0]  front_slot;
      logic [11:0] front_length;
      logic [7:0]  read_data;
   } pra_rsp_type;

endpackage

// File: hw/rtl/pra_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pra_chan_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface pra_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/per_channel_packet_reassembler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_channel_packet_reassembler_top
// Per-channel length-prefixed packet reassembly into a pool of byte slots.
// ----------------------------------------------------------------------------
// One request at a time. A push of a byte into an open packet, a header byte,
// a dropped byte or a pop goes from acceptance through the process state to
// the response; a read also waits for the registered read of the slot memory.
// A push that completes a header and opens a slot replays one byte per cycle
// into the slot through the single write port: the gathered header bytes,
// plus HEADER_BYTES for a built header.
// The next request is taken in the cycle its predecessor's response leaves,
// and a response can wait in the output register while the next is worked.
module per_channel_packet_reassembler_top import pra_pkg::*; #(
   parameter int NUM_CHANNELS       = NUM_CHANNELS_DEF,
   parameter int NUM_SLOTS          = NUM_SLOTS_DEF,
   parameter int SLOT_PAYLOAD_BYTES = SLOT_PAYLOAD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   pra_chan_if.sink    req_chan,
   pra_chan_if.source  rsp_chan
);
   localparam int DEPTH  = NUM_SLOTS * (SLOT_PAYLOAD_BYTES + HEADER_BYTES);
   localparam int ADDR_W = $clog2(DEPTH);

   logic              ignore_ff;
   logic              rsp_valid_ff;
   pra_rsp_type       rsp_data_ff;
   logic              out_valid, out_ready;
   pra_rsp_type       out_data;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff <= 1'b0;
      end else if (csr_wr_en) begin
         ignore_ff <= csr_wr_data;
      end
   end

   pra_ctrl #(
      .NUM_CHANNELS       (NUM_CHANNELS),
      .NUM_SLOTS          (NUM_SLOTS),
      .SLOT_PAYLOAD_BYTES (SLOT_PAYLOAD_BYTES),
      .ADDR_W             (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .ignore_header (ignore_ff),
      .in_valid      (req_chan.valid),
      .in_ready      (req_chan.ready),
      .in_data       (req_chan.payload),
      .out_valid     (out_valid),
      .out_ready     (out_ready),
      .out_data      (out_data),
      .mem_wr_en     (wr_en),
      .mem_wr_addr   (wr_addr),
      .mem_wr_data   (wr_data),
      .mem_rd_en     (rd_en),
      .mem_rd_addr   (rd_addr),
      .mem_rd_data   (rd_data)
   );

   pra_slot_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_slot_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // output register: hold the response until taken
   assign out_ready = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= out_valid;
      end
      if (out_ready && out_valid) begin
         rsp_data_ff <= out_data;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;
endmodule

// File: hw/rtl/pra_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pra_slot_mem
// Byte store of all packet slots: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pra_slot_mem #(
   parameter int DEPTH  = 32864,
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data_ff
);
   logic [7:0] slot_mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end
endmodule

// File: hw/rtl/pra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pra_ctrl
// Request sequencer: channel header gathering, slot pool, packet order queue,
// slot memory writes and reads.
// ----------------------------------------------------------------------------
module pra_ctrl import pra_pkg::*; #(
   parameter int NUM_CHANNELS       = NUM_CHANNELS_DEF,
   parameter int NUM_SLOTS          = NUM_SLOTS_DEF,
   parameter int SLOT_PAYLOAD_BYTES = SLOT_PAYLOAD_BYTES_DEF,
   parameter int ADDR_W             = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ignore_header,
   input  logic              in_valid,
   output logic              in_ready,
   input  pra_req_type       in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output pra_rsp_type       out_data,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [7:0]        mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [7:0]        mem_rd_data
);
   localparam int STRIDE = SLOT_PAYLOAD_BYTES + HEADER_BYTES;
   localparam int LEN_W  = $clog2(STRIDE + 1);
   localparam int SL_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int HC_W   = $clog2(HEADER_BYTES + 1);
   localparam int RP_W   = $clog2(2 * HEADER_BYTES + 1);
   localparam int ROW_W  = 8 * HEADER_BYTES;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PROC   = 3'd1;
   localparam logic [2:0] ST_REPLAY = 3'd2;
   localparam logic [2:0] ST_RDWAIT = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   // sequencer and held request
   logic [2:0]       state_ff, state_in;
   pra_req_type      req_ff, req_in;
   logic [3:0]       stat_ff, stat_in;
   logic [SL_W-1:0]  dslot_ff, dslot_in;
   logic [LEN_W-1:0] dlen_ff, dlen_in;
   logic             rdok_ff, rdok_in;

   // header replay into a freshly opened slot
   logic [RP_W-1:0]  rep_idx_ff, rep_idx_in;
   logic [LEN_W-1:0] rep_len_ff, rep_len_in;
   logic [SL_W-1:0]  rep_slot_ff, rep_slot_in;
   logic [ROW_W-1:0] rep_row_ff, rep_row_in;
   logic             rep_built_ff, rep_built_in;
   logic [LEN_W-1:0] rep_total_ff, rep_total_in;

   // per channel state
   logic [ROW_W-1:0]        hrow_ff   [NUM_CHANNELS];
   logic [ROW_W-1:0]        hrow_in   [NUM_CHANNELS];
   logic [HC_W-1:0]         hcnt_ff   [NUM_CHANNELS];
   logic [HC_W-1:0]         hcnt_in   [NUM_CHANNELS];
   logic [SL_W-1:0]         open_s_ff [NUM_CHANNELS];
   logic [SL_W-1:0]         open_s_in [NUM_CHANNELS];
   logic [LEN_W-1:0]        open_t_ff [NUM_CHANNELS];
   logic [LEN_W-1:0]        open_t_in [NUM_CHANNELS];
   logic [LEN_W-1:0]        open_f_ff [NUM_CHANNELS];
   logic [LEN_W-1:0]        open_f_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] open_v_ff, open_v_in;
   logic [NUM_CHANNELS-1:0] drop_ff, drop_in;

   // per slot state and allocation order
   logic [NUM_SLOTS-1:0] used_ff, used_in;
   logic [NUM_SLOTS-1:0] comp_ff, comp_in;
   logic [2:0]           schan_ff [NUM_SLOTS];
   logic [2:0]           schan_in [NUM_SLOTS];
   logic [LEN_W-1:0]     stot_ff  [NUM_SLOTS];
   logic [LEN_W-1:0]     stot_in  [NUM_SLOTS];
   logic [SL_W-1:0]      fifo_ff  [NUM_SLOTS];
   logic [SL_W-1:0]      fifo_in  [NUM_SLOTS];
   logic [SL_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // decode of the held request
   logic             left_one;
   logic [15:0]      left_eff;
   logic             ch_ok;
   logic [CH_W-1:0]  chi;
   logic [HC_W-1:0]  n_eff, n1;
   logic [ROW_W-1:0] new_row;
   logic             magic;
   logic [31:0]      hdr_len;
   logic [17:0]      avail;
   logic             free_found;
   logic [SL_W-1:0]  free_idx;
   logic [SL_W-1:0]  tail_idx;
   logic [SL_W-1:0]  head_next;
   logic [SL_W-1:0]  rs_idx;
   logic             rs_ok;
   logic             hd_built, hd_reject, hd_done;
   logic [3:0]       hd_status;
   logic [LEN_W-1:0] hd_total, hd_fill;
   logic [LEN_W:0]   fill_next;
   logic [SL_W-1:0]  pop_slot;
   logic [RP_W-1:0]  rep_ri;
   logic [7:0]       rep_row_byte, rep_hdr_byte, rep_byte;
   logic [31:0]      rep_tot32;

   function automatic logic [ADDR_W-1:0] slot_base(input logic [SL_W-1:0] s);
      slot_base = ADDR_W'(s) * ADDR_W'(STRIDE);
   endfunction

   // decode channel, header and free slot
   assign left_one  = (req_ff.bytes_left <= 16'd1);
   assign left_eff  = left_one ? 16'd1 : req_ff.bytes_left;
   assign ch_ok     = (32'(req_ff.channel) < NUM_CHANNELS);
   assign chi       = CH_W'({5'd0, req_ff.channel});
   assign n_eff     = (32'(hcnt_ff[chi]) >= HEADER_BYTES) ? HC_W'(HEADER_BYTES - 1)
                                                          : hcnt_ff[chi];
   assign n1        = n_eff + HC_W'(1);
   assign magic     = (new_row[7:0] == MAGIC0) && (new_row[15:8] == MAGIC1);
   assign avail     = 18'(left_eff) + 18'(n1) - 18'd1;
   assign rs_idx    = SL_W'(req_ff.read_slot);
   assign rs_ok     = (32'(req_ff.read_slot) < NUM_SLOTS) && (32'(req_ff.read_offset) < STRIDE);
   assign pop_slot  = fifo_ff[head_ff];
   assign head_next = (32'(head_ff) == NUM_SLOTS - 1) ? '0 : head_ff + SL_W'(1);
   assign fill_next = (LEN_W + 1)'(open_f_ff[chi]) + (LEN_W + 1)'(1);

   always_comb begin
      new_row = hrow_ff[chi];
      for (int i = 0; i < HEADER_BYTES; i++) begin
         if (HC_W'(i) == n_eff) begin
            new_row[i*8 +: 8] = req_ff.data_byte;
         end
      end
   end

   // little-endian length from the header bytes after the magic
   always_comb begin
      hdr_len = '0;
      for (int i = 2; i < 2 + LEN_BYTES; i++) begin
         if (i < HEADER_BYTES) begin
            hdr_len[(i-2)*8 +: 8] = new_row[i*8 +: 8];
         end
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SL_W'(i);
         end
      end
   end

   // queue tail wraps modulo the slot count
   always_comb begin
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(cnt_ff);
      if (32'(sum) >= NUM_SLOTS) begin
         sum = sum - (CNT_W + 1)'(NUM_SLOTS);
      end
      tail_idx = SL_W'(sum);
   end

   // completed header: accept, build or reject
   always_comb begin
      hd_built  = !req_ff.from_network || (!magic && ignore_header);
      hd_reject = 1'b0;
      hd_status = STAT_STORED;
      hd_total  = LEN_W'(hdr_len);
      if (req_ff.from_network && magic) begin
         if (hdr_len < 32'(HEADER_BYTES) || hdr_len > 32'(STRIDE)) begin
            hd_reject = 1'b1;
            hd_status = STAT_BAD_LEN;
         end
      end else if (req_ff.from_network && !ignore_header) begin
         hd_reject = 1'b1;
         hd_status = STAT_BAD_HDR;
      end
      if (hd_built) begin
         if (32'(avail) > SLOT_PAYLOAD_BYTES) begin
            hd_reject = 1'b1;
            hd_status = STAT_BAD_LEN;
         end else begin
            hd_total = LEN_W'(avail + 18'(HEADER_BYTES));
         end
      end
      if (!hd_reject && !free_found) begin
         hd_reject = 1'b1;
         hd_status = STAT_NO_SLOT;
      end
      hd_fill = LEN_W'(n1) + (hd_built ? LEN_W'(HEADER_BYTES) : LEN_W'(0));
      hd_done = (hd_fill >= hd_total);
      if (!hd_reject) begin
         hd_status = hd_done ? STAT_COMPLETE : STAT_STORED;
      end
   end

   // byte for the current replay step: built header, then gathered bytes
   assign rep_tot32 = 32'(rep_total_ff);
   assign rep_ri    = rep_built_ff ? rep_idx_ff - RP_W'(HEADER_BYTES) : rep_idx_ff;

   always_comb begin
      rep_row_byte = 8'd0;
      for (int i = 0; i < HEADER_BYTES; i++) begin
         if (RP_W'(i) == rep_ri) begin
            rep_row_byte = rep_row_ff[i*8 +: 8];
         end
      end
      if (rep_idx_ff == RP_W'(0)) begin
         rep_hdr_byte = MAGIC0;
      end else if (rep_idx_ff == RP_W'(1)) begin
         rep_hdr_byte = MAGIC1;
      end else if (32'(rep_idx_ff) < 2 + LEN_BYTES) begin
         rep_hdr_byte = 8'(rep_tot32 >> (8 * (32'(rep_idx_ff) - 2)));
      end else begin
         rep_hdr_byte = 8'd0;
      end
      rep_byte = (rep_built_ff && 32'(rep_idx_ff) < HEADER_BYTES) ? rep_hdr_byte
                                                                  : rep_row_byte;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      stat_in      = stat_ff;
      dslot_in     = dslot_ff;
      dlen_in      = dlen_ff;
      rdok_in      = rdok_ff;
      rep_idx_in   = rep_idx_ff;
      rep_len_in   = rep_len_ff;
      rep_slot_in  = rep_slot_ff;
      rep_row_in   = rep_row_ff;
      rep_built_in = rep_built_ff;
      rep_total_in = rep_total_ff;
      hrow_in      = hrow_ff;
      hcnt_in      = hcnt_ff;
      open_s_in    = open_s_ff;
      open_t_in    = open_t_ff;
      open_f_in    = open_f_ff;
      open_v_in    = open_v_ff;
      drop_in      = drop_ff;
      used_in      = used_ff;
      comp_in      = comp_ff;
      schan_in     = schan_ff;
      stot_in      = stot_ff;
      fifo_in      = fifo_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      in_ready     = 1'b0;
      out_valid    = 1'b0;
      out_data     = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;

      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               req_in   = in_data;
               state_in = ST_PROC;
            end
         end

         ST_PROC: begin
            dslot_in = '0;
            dlen_in  = '0;
            rdok_in  = 1'b0;
            state_in = ST_EMIT;
            if (req_ff.mode == MODE_READ || req_ff.mode == MODE_RSVD) begin
               // issue the slot read, data lands next cycle
               stat_in     = STAT_READ;
               dslot_in    = rs_idx;
               rdok_in     = rs_ok;
               mem_rd_en   = rs_ok;
               mem_rd_addr = slot_base(rs_idx) + ADDR_W'(req_ff.read_offset);
               state_in    = ST_RDWAIT;
            end else if (req_ff.mode == MODE_POP) begin
               if (cnt_ff == '0) begin
                  stat_in = STAT_EMPTY;
               end else begin
                  // free the oldest slot and close any channel still filling it
                  stat_in           = STAT_POPPED;
                  dslot_in          = pop_slot;
                  dlen_in           = stot_ff[pop_slot];
                  used_in[pop_slot] = 1'b0;
                  comp_in[pop_slot] = 1'b0;
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     if (open_v_ff[c] && open_s_ff[c] == pop_slot) begin
                        open_v_in[c] = 1'b0;
                     end
                  end
                  head_in = head_next;
                  cnt_in  = cnt_ff - CNT_W'(1);
               end
            end else if (!ch_ok) begin
               stat_in = STAT_BAD_HDR;
            end else if (open_v_ff[chi]) begin
               // store the byte into the open packet
               if (32'(open_f_ff[chi]) < STRIDE) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = slot_base(open_s_ff[chi]) + ADDR_W'(open_f_ff[chi]);
                  mem_wr_data = req_ff.data_byte;
               end
               open_f_in[chi] = LEN_W'(fill_next);
               dslot_in       = open_s_ff[chi];
               stat_in        = STAT_STORED;
               if (fill_next >= (LEN_W + 1)'(open_t_ff[chi])) begin
                  open_v_in[chi]          = 1'b0;
                  comp_in[open_s_ff[chi]] = 1'b1;
                  stat_in                 = STAT_COMPLETE;
                  dlen_in                 = open_t_ff[chi];
               end
            end else if (drop_ff[chi]) begin
               // discard the rest of a rejected chunk
               stat_in = STAT_BAD_HDR;
               if (left_one) begin
                  drop_in[chi] = 1'b0;
               end
            end else begin
               hrow_in[chi] = new_row;
               if (req_ff.from_network && 32'(n1) < HEADER_BYTES) begin
                  hcnt_in[chi] = n1;
                  stat_in      = STAT_HDR_PEND;
               end else begin
                  hcnt_in[chi] = '0;
                  stat_in      = hd_status;
                  if (hd_reject) begin
                     if (!left_one) begin
                        drop_in[chi] = 1'b1;
                     end
                  end else begin
                     // open the packet and replay its header bytes
                     used_in[free_idx]  = 1'b1;
                     comp_in[free_idx]  = hd_done;
                     schan_in[free_idx] = req_ff.channel;
                     stot_in[free_idx]  = hd_total;
                     fifo_in[tail_idx]  = free_idx;
                     cnt_in             = cnt_ff + CNT_W'(1);
                     open_v_in[chi]     = !hd_done;
                     open_s_in[chi]     = free_idx;
                     open_t_in[chi]     = hd_total;
                     open_f_in[chi]     = hd_fill;
                     dslot_in           = free_idx;
                     dlen_in            = hd_done ? hd_total : '0;
                     rep_idx_in         = '0;
                     rep_len_in         = hd_fill;
                     rep_slot_in        = free_idx;
                     rep_row_in         = new_row;
                     rep_built_in       = hd_built;
                     rep_total_in       = hd_total;
                     state_in           = ST_REPLAY;
                  end
               end
            end
         end

         ST_REPLAY: begin
            // one byte into the new slot each cycle
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_base(rep_slot_ff) + ADDR_W'(rep_idx_ff);
            mem_wr_data = rep_byte;
            rep_idx_in  = rep_idx_ff + RP_W'(1);
            if (LEN_W'(rep_idx_ff) + LEN_W'(1) >= rep_len_ff) begin
               state_in = ST_EMIT;
            end
         end

         ST_RDWAIT: begin
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            // present the response with the queue front after this request
            out_valid            = 1'b1;
            out_data.status      = stat_ff;
            out_data.done_slot   = 4'(dslot_ff);
            out_data.done_length = 12'(dlen_ff);
            out_data.read_data   = rdok_ff ? mem_rd_data : 8'd0;
            if (cnt_ff != '0) begin
               out_data.front_ready   = comp_ff[pop_slot];
               out_data.front_channel = schan_ff[pop_slot];
               out_data.front_slot    = 4'(pop_slot);
               out_data.front_length  = 12'(stot_ff[pop_slot]);
            end
            if (out_ready) begin
               in_ready = 1'b1;
               if (in_valid) begin
                  req_in   = in_data;
                  state_in = ST_PROC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         open_v_ff <= '0;
         drop_ff   <= '0;
         used_ff   <= '0;
         comp_ff   <= '0;
         head_ff   <= '0;
         cnt_ff    <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            hcnt_ff[c] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         open_v_ff <= open_v_in;
         drop_ff   <= drop_in;
         used_ff   <= used_in;
         comp_ff   <= comp_in;
         head_ff   <= head_in;
         cnt_ff    <= cnt_in;
         hcnt_ff   <= hcnt_in;
      end
      req_ff       <= req_in;
      stat_ff      <= stat_in;
      dslot_ff     <= dslot_in;
      dlen_ff      <= dlen_in;
      rdok_ff      <= rdok_in;
      rep_idx_ff   <= rep_idx_in;
      rep_len_ff   <= rep_len_in;
      rep_slot_ff  <= rep_slot_in;
      rep_row_ff   <= rep_row_in;
      rep_built_ff <= rep_built_in;
      rep_total_ff <= rep_total_in;
      hrow_ff      <= hrow_in;
      open_s_ff    <= open_s_in;
      open_t_ff    <= open_t_in;
      open_f_ff    <= open_f_in;
      schan_ff     <= schan_in;
      stot_ff      <= stot_in;
      fifo_ff      <= fifo_in;
   end

   // every queued packet owns exactly one used slot
   a_used_matches_queue: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(cnt_ff))
      else $error("used slot count differs from queue depth");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= NUM_SLOTS)
      else $error("order queue overflow");

   a_read_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROC && (req_ff.mode == MODE_READ || req_ff.mode == MODE_RSVD))
      |=> state_ff == ST_RDWAIT)
      else $error("read did not wait for memory data");

   a_replay_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLAY) |-> (mem_wr_en && used_ff[rep_slot_ff]))
      else $error("replay write into a slot that is not held");
endmodule

// File: test/tb_per_channel_packet_reassembler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_channel_packet_reassembler_top
// Self-checking bench for the per-channel packet reassembler. A queue of
// requests, built as interleaved per-channel byte chunks with pops and reads
// mixed in, feeds a clocked driver. A behavioral copy of the slot pool
// predicts each response, and a clocked monitor checks every response in order.
// ----------------------------------------------------------------------------
module tb_per_channel_packet_reassembler_top;
   import pra_pkg::*;

   localparam int NCH       = NUM_CHANNELS_DEF;
   localparam int NSL       = NUM_SLOTS_DEF;
   localparam int PAY       = SLOT_PAYLOAD_BYTES_DEF;
   localparam int STRIDE    = PAY + HEADER_BYTES;
   localparam int CYC_LIMIT = 600000;
   localparam int SETTLE    = 24;

   // chunk flavors for the random part
   localparam int KIND_GOOD    = 0;
   localparam int KIND_BADLEN  = 1;
   localparam int KIND_NOMAGIC = 2;
   localparam int KIND_TX      = 3;
   localparam int KIND_PARTIAL = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   pra_chan_if #(.payload_type(pra_req_type)) req_if ();
   pra_chan_if #(.payload_type(pra_rsp_type)) rsp_if ();

   per_channel_packet_reassembler_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   always #4 clock = ~clock;

   // shadow of the slot pool
   logic [7:0]  pool_mem [NSL*STRIDE];
   int          pool_hiw [NSL];
   bit          pool_used [NSL];
   bit          pool_done [NSL];
   logic [2:0]  pool_chan [NSL];
   int          pool_total [NSL];
   logic [7:0]  hdr_buf [NCH][HEADER_BYTES];
   int          hdr_cnt [NCH];
   bit          fill_open [NCH];
   int          fill_slot [NCH];
   int          fill_total [NCH];
   int          fill_count [NCH];
   bit          chunk_drop [NCH];
   int          order_q [NSL];
   int          order_head;
   int          order_cnt;
   bit          ignore_hdr;

   pra_req_type pending_req [$];
   pra_rsp_type expected_rsp [$];
   int          errors = 0;
   int          n_req = 0;
   int          n_rsp = 0;
   int          n_done = 0;
   int          cycles = 0;
   bit          last_phase = 0;
   bit          calm;
   bit          req_fired = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;

   // write one byte at the fill pointer of a channel's open packet
   function automatic void store_byte(int ch, logic [7:0] b);
      int f;
      f = fill_count[ch];
      if (f < STRIDE) begin
         pool_mem[fill_slot[ch]*STRIDE + f] = b;
         if (f + 1 > pool_hiw[fill_slot[ch]]) pool_hiw[fill_slot[ch]] = f + 1;
      end
      fill_count[ch] = f + 1;
   endfunction

   // advance the shadow pool by one request and return its response
   function automatic pra_rsp_type predict_rsp(pra_req_type r);
      pra_rsp_type o;
      int left, n, total, avail, s, i, c, ch;
      bit built, reject;
      o = '0;
      ch = int'(r.channel);
      left = (r.bytes_left == 0) ? 1 : int'(r.bytes_left);
      if (r.mode[1]) begin
         o.status = STAT_READ;
         o.done_slot = r.read_slot;
         if (r.read_offset < STRIDE) o.read_data = pool_mem[r.read_slot*STRIDE + r.read_offset];
      end else if (r.mode == MODE_POP) begin
         if (order_cnt == 0) begin
            o.status = STAT_EMPTY;
         end else begin
            s = order_q[order_head];
            o.status = STAT_POPPED;
            o.done_slot = 4'(s);
            o.done_length = 12'(pool_total[s]);
            pool_used[s] = 0;
            pool_done[s] = 0;
            for (c = 0; c < NCH; c++)
               if (fill_open[c] && fill_slot[c] == s) fill_open[c] = 0;
            order_head = (order_head + 1) % NSL;
            order_cnt--;
         end
      end else if (fill_open[ch]) begin
         store_byte(ch, r.data_byte);
         o.done_slot = 4'(fill_slot[ch]);
         if (fill_count[ch] >= fill_total[ch]) begin
            fill_open[ch] = 0;
            pool_done[fill_slot[ch]] = 1;
            o.status = STAT_COMPLETE;
            o.done_length = 12'(fill_total[ch]);
         end else begin
            o.status = STAT_STORED;
         end
      end else if (chunk_drop[ch]) begin
         o.status = STAT_BAD_HDR;
         if (left == 1) chunk_drop[ch] = 0;
      end else begin
         n = hdr_cnt[ch];
         if (n >= HEADER_BYTES) n = HEADER_BYTES - 1;
         hdr_buf[ch][n] = r.data_byte;
         n++;
         if (r.from_network && n < HEADER_BYTES) begin
            hdr_cnt[ch] = n;
            o.status = STAT_HDR_PEND;
         end else begin
            built = !r.from_network;
            reject = 0;
            total = 0;
            hdr_cnt[ch] = 0;
            if (r.from_network) begin
               if (hdr_buf[ch][0] == MAGIC0 && hdr_buf[ch][1] == MAGIC1) begin
                  for (i = 2; i < HEADER_BYTES && i < 2 + LEN_BYTES; i++)
                     total = total | (int'(hdr_buf[ch][i]) << (8*(i-2)));
                  if (total < HEADER_BYTES || total > STRIDE || total < 0) begin
                     o.status = STAT_BAD_LEN;
                     reject = 1;
                  end
               end else if (ignore_hdr) begin
                  built = 1;
               end else begin
                  o.status = STAT_BAD_HDR;
                  reject = 1;
               end
            end
            if (built) begin
               avail = n - 1 + left;
               if (avail > PAY) begin
                  o.status = STAT_BAD_LEN;
                  reject = 1;
               end else begin
                  total = avail + HEADER_BYTES;
               end
            end
            if (!reject) begin
               s = -1;
               for (i = NSL - 1; i >= 0; i--)
                  if (!pool_used[i]) s = i;
               if (s < 0) begin
                  o.status = STAT_NO_SLOT;
                  reject = 1;
               end else begin
                  pool_used[s] = 1;
                  pool_done[s] = 0;
                  pool_chan[s] = 3'(ch);
                  pool_total[s] = total;
                  order_q[(order_head + order_cnt) % NSL] = s;
                  order_cnt++;
                  fill_open[ch] = 1;
                  fill_slot[ch] = s;
                  fill_total[ch] = total;
                  fill_count[ch] = 0;
                  if (built) begin
                     store_byte(ch, MAGIC0);
                     store_byte(ch, MAGIC1);
                     for (i = 2; i < HEADER_BYTES; i++)
                        store_byte(ch, (i < 2 + LEN_BYTES) ? 8'((total >> (8*(i-2)))) : 8'h00);
                  end
                  for (i = 0; i < n; i++) store_byte(ch, hdr_buf[ch][i]);
                  o.done_slot = 4'(s);
                  if (fill_count[ch] >= fill_total[ch]) begin
                     fill_open[ch] = 0;
                     pool_done[s] = 1;
                     o.status = STAT_COMPLETE;
                     o.done_length = 12'(total);
                  end else begin
                     o.status = STAT_STORED;
                  end
               end
            end
            if (reject && left > 1) chunk_drop[ch] = 1;
         end
      end
      if (order_cnt > 0) begin
         s = order_q[order_head];
         o.front_slot = 4'(s);
         o.front_ready = pool_done[s];
         o.front_channel = pool_chan[s];
         o.front_length = 12'(pool_total[s]);
      end
      return o;
   endfunction

   // queue one request and its predicted response
   task automatic send(pra_req_type r);
      pending_req.insert(pending_req.size(), r);
      expected_rsp.insert(expected_rsp.size(), predict_rsp(r));
      n_req++;
   endtask

   function automatic pra_req_type make_req(logic [1:0] mode, int ch, logic [7:0] b,
                                            bit net, int left, int rs, int ro);
      pra_req_type r;
      r.mode = mode;
      r.channel = 3'(ch);
      r.data_byte = b;
      r.from_network = net;
      r.bytes_left = 16'(left);
      r.read_slot = 4'(rs);
      r.read_offset = 12'(ro);
      return r;
   endfunction

   task automatic send_push(int ch, logic [7:0] b, bit net, int left);
      send(make_req(MODE_PUSH, ch, b, net, left, $urandom_range(0, 15), $urandom_range(0, 4095)));
   endtask

   task automatic send_pop();
      send(make_req(MODE_POP, $urandom_range(0, 7), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), $urandom_range(0, 65535), $urandom_range(0, 15),
                    $urandom_range(0, 4095)));
   endtask

   // read a written byte, or now and then an address past the slot
   task automatic send_read();
      int s, ro;
      s = $urandom_range(0, NSL - 1);
      if (pool_hiw[s] > 0 && $urandom_range(0, 9) != 0) ro = $urandom_range(0, pool_hiw[s] - 1);
      else ro = $urandom_range(STRIDE, 4095);
      send(make_req($urandom_range(0, 3) == 0 ? MODE_RSVD : MODE_READ, $urandom_range(0, 7),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 65535), s, ro));
   endtask

   // build one chunk of bytes for a channel
   task automatic build_chunk(ref pra_req_type q[$], input int ch, input int kind,
                              input int big);
      logic [7:0] b [$];
      int total, i, len;
      bit net;
      net = 1;
      case (kind)
         KIND_GOOD, KIND_BADLEN: begin
            if (kind == KIND_GOOD) begin
               total = HEADER_BYTES + (big > 0 ? big :
                       ($urandom_range(0, 40) == 0 ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 30)));
               len = total;
            end else begin
               total = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 5)
                                                   : $urandom_range(STRIDE + 1, 32'h7fffffff);
               if ($urandom_range(0, 3) == 0) total = $urandom();
               len = HEADER_BYTES + $urandom_range(0, 3);
            end
            b.insert(b.size(), MAGIC0);
            b.insert(b.size(), MAGIC1);
            for (i = 0; i < LEN_BYTES; i++) b.insert(b.size(), 8'(total >> (8*i)));
            while (b.size() < len) b.insert(b.size(), 8'($urandom_range(0, 255)));
         end
         KIND_NOMAGIC: begin
            len = $urandom_range(1, 14);
            for (i = 0; i < len; i++) b.insert(b.size(), 8'($urandom_range(0, 255)));
         end
         KIND_PARTIAL: begin
            len = $urandom_range(1, 5);
            b.insert(b.size(), MAGIC0);
            b.insert(b.size(), MAGIC1);
            while (b.size() < len + 2) b.insert(b.size(), 8'($urandom_range(0, 255)));
            for (i = 0; i < len; i++)
               q.insert(q.size(), make_req(MODE_PUSH, ch, b[i], 1, 40 - i, 0, 0));
            b.delete();
            net = 0;
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++) b.insert(b.size(), 8'($urandom_range(0, 255)));
         end
         default: begin
            net = 0;
            len = $urandom_range(1, 20);
            for (i = 0; i < len; i++) b.insert(b.size(), 8'($urandom_range(0, 255)));
         end
      endcase
      for (i = 0; i < b.size(); i++)
         q.insert(q.size(), make_req(MODE_PUSH, ch, b[i], net, b.size() - i,
                                     $urandom_range(0, 15), $urandom_range(0, 4095)));
   endtask

   // interleave a few channel chunks with pops, reads and stray bytes
   task automatic run_burst(input int big);
      pra_req_type strm [3][$];
      int k, j, pick, kind;
      k = (big > 0) ? 1 : $urandom_range(1, 3);
      for (j = 0; j < k; j++) begin
         pick = $urandom_range(0, 19);
         kind = (pick < 11) ? KIND_GOOD : (pick < 13) ? KIND_BADLEN :
                (pick < 16) ? KIND_NOMAGIC : (pick < 18) ? KIND_TX : KIND_PARTIAL;
         build_chunk(strm[j], (big > 0) ? 7 : (j * 3 + $urandom_range(0, 2)) % NCH,
                     (big > 0) ? KIND_GOOD : kind, big);
      end
      while (strm[0].size() + strm[1].size() + strm[2].size() > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_read();
         end else if ((order_cnt >= 14 && pick < 50) || pick < 14) begin
            if (order_cnt == 0 || pool_done[order_q[order_head]] || $urandom_range(0, 9) == 0)
               send_pop();
         end else if (pick < 17) begin
            send_push($urandom_range(0, 7), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 65535));
         end else begin
            j = $urandom_range(0, 2);
            if (strm[j].size() > 0) send(strm[j].pop_front());
         end
      end
   endtask

   // change the register only once the block has drained
   task automatic write_ignore(bit v);
      wait (pending_req.size() == 0 && expected_rsp.size() == 0);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      ignore_hdr = v;
   endtask

   task automatic run_directed();
      int i;
      send_pop();
      send(make_req(MODE_RSVD, 0, 8'h00, 0, 1, 15, 4095));
      // header-only packet that completes on its last header byte
      send_push(0, MAGIC0, 1, 6);
      send_push(0, MAGIC1, 1, 5);
      send_push(0, 8'd6, 1, 4);
      for (i = 3; i > 0; i--) send_push(0, 8'h00, 1, i);
      // length below the header, then above the slot with the rest dropped
      send_push(1, MAGIC0, 1, 6);
      send_push(1, MAGIC1, 1, 5);
      for (i = 4; i > 0; i--) send_push(1, (i == 4) ? 8'd5 : 8'h00, 1, i);
      send_push(2, MAGIC0, 1, 8);
      send_push(2, MAGIC1, 1, 7);
      send_push(2, 8'h07, 1, 6);
      send_push(2, 8'h08, 1, 5);
      send_push(2, 8'h00, 1, 4);
      send_push(2, 8'h00, 1, 3);
      send_push(2, 8'hff, 1, 2);
      send_push(2, 8'h11, 1, 1);
      // transmit byte with zero left, oversized transmit chunk and its drop
      send_push(3, 8'hff, 0, 0);
      send_push(4, 8'h5a, 0, 65535);
      send_push(4, 8'ha5, 0, 1);
      // pending network header replayed ahead of a transmit byte
      send_push(5, MAGIC0, 1, 5);
      send_push(5, MAGIC1, 1, 4);
      send_push(5, 8'h33, 0, 1);
      // largest built packet, and two bytes too many after a pending byte
      send_push(7, 8'h01, 0, PAY);
      send_push(6, 8'h00, 1, 1);
      send_push(6, 8'h02, 0, PAY + 1);
      send(make_req(MODE_READ, 0, 8'h00, 0, 1, 0, 0));
      send_pop();
      send_pop();
   endtask

   // driver: present the next request once the previous one is taken
   always @(posedge clock) req_fired <= req_if.valid && req_if.ready;

   always @(negedge clock) begin
      calm = last_phase && pending_req.size() < 300;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.payload <= '0;
      end else if (!req_if.valid || req_fired) begin
         if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_req.size() > 0) begin
            req_if.payload <= pending_req.pop_front();
            req_if.valid <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 3);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!calm && $urandom_range(0, 4) == 0) rsp_gap = $urandom_range(1, 3);
      end
   end

   // monitor: check each response against the oldest prediction
   always @(posedge clock) begin
      pra_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         n_rsp++;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected response %p", $realtime, rsp_if.payload);
         end else begin
            want = expected_rsp.pop_front();
            if (want.status == STAT_COMPLETE) n_done++;
            if (rsp_if.payload !== want) begin
               errors++;
               $display("%0t: mismatch expected %p actual %p", $realtime, want, rsp_if.payload);
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYC_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int ph, i;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      for (i = 0; i < NSL*STRIDE; i++) pool_mem[i] = 8'h00;
      for (i = 0; i < NSL; i++) begin
         pool_hiw[i] = 0; pool_used[i] = 0; pool_done[i] = 0;
         pool_chan[i] = 0; pool_total[i] = 0; order_q[i] = 0;
      end
      for (i = 0; i < NCH; i++) begin
         hdr_cnt[i] = 0; fill_open[i] = 0; fill_slot[i] = 0;
         fill_total[i] = 0; fill_count[i] = 0; chunk_drop[i] = 0;
      end
      order_head = 0;
      order_cnt = 0;
      ignore_hdr = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_ignore(0);
      run_directed();
      for (ph = 0; ph < 4; ph++) begin
         if (ph > 0) write_ignore(ph[0]);
         last_phase = (ph == 3);
         i = n_req;
         if (ph == 2) run_burst(PAY / 8);
         while (n_req - i < 420) run_burst(0);
      end
      wait (pending_req.size() == 0);
      wait (expected_rsp.size() == 0);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d requests over both header modes; %0d responses checked, %0d packets completed.",
               n_req, n_rsp, n_done);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
